// ===== hdl/pgb_pkg.sv =====
// Shared types, constants and codes for the particle grid binning unit.
`default_nettype none
package pgb_pkg;

  localparam int GRID_ROWS_DEF     = 64;
  localparam int GRID_COLS_DEF     = 64;
  localparam int SLOTS_DEF         = 15;
  localparam int MAX_PARTICLES_DEF = 65536;

  localparam int EPOCH_W    = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_W      = 31;
  localparam int POS_W      = 32;

  localparam logic [REG_W-1:0] CELL_SIZE_RST = 31'd65536;
  localparam logic [REG_W-1:0] DOMAIN_RST    = 31'd4194304;

  localparam int IN_TDATA_W  = 2 * POS_W;

  localparam int IDX_W   = 16;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 17;

  localparam int OUT_ROW_LSB    = IDX_W;
  localparam int OUT_COL_LSB    = OUT_ROW_LSB + ROW_W;
  localparam int OUT_SLOT_LSB   = OUT_COL_LSB + COL_W;
  localparam int OUT_STORED_BIT = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_ALL_BIT    = OUT_STORED_BIT + 1;
  localparam int OUT_TOTAL_LSB  = OUT_ALL_BIT + 1;
  localparam int OUT_USED_W     = OUT_TOTAL_LSB + TOTAL_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REG_CELL_SIZE     = 2'd0,
    REG_DOMAIN_LENGTH = 2'd1,
    REG_DOMAIN_DEPTH  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_X_INIT,
    ST_X_STEP,
    ST_Y_INIT,
    ST_Y_STEP,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic div_init;
    logic div_step;
    logic axis_y;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic wrap;
    logic clr_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/pgb_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module pgb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hdl/pgb_ctrl.sv =====
// Sequencing state machine for clearing, division steps and cell update.
`default_nettype none
module pgb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pgb_pkg::status_t sts,
  output pgb_pkg::cmd_t    cmd
);
  import pgb_pkg::*;

  state_t state, state_next;
  logic   pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = pend ? ST_X_INIT : ST_IDLE;
          pend_next  = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.first && sts.wrap) begin
            state_next = ST_CLEAR;
            pend_next  = 1'b1;
          end else begin
            state_next = ST_X_INIT;
          end
        end
      end
      ST_X_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_X_STEP;
      end
      ST_X_STEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_Y_INIT;
        end
      end
      ST_Y_INIT: begin
        cmd.div_init = 1'b1;
        cmd.axis_y   = 1'b1;
        state_next   = ST_Y_STEP;
      end
      ST_Y_STEP: begin
        cmd.div_step = 1'b1;
        cmd.axis_y   = 1'b1;
        if (sts.div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.wr     = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/pgb_datapath.sv =====
// Coordinate divider, cell count store, frame counters and result register.
`default_nettype none
module pgb_datapath #(
  parameter int GRID_ROWS      = 64,
  parameter int GRID_COLS      = 64,
  parameter int SLOTS_PER_CELL = 15,
  parameter int MAX_PARTICLES  = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pgb_pkg::cmd_t                    cmd,
  output pgb_pkg::status_t                 sts,
  input  logic                             in_first,
  input  logic                             in_last,
  input  logic [pgb_pkg::POS_W-1:0]        in_pos_x,
  input  logic [pgb_pkg::POS_W-1:0]        in_pos_y,
  input  logic [pgb_pkg::REG_W-1:0]        cell_size,
  input  logic [pgb_pkg::REG_W-1:0]        domain_length,
  input  logic [pgb_pkg::REG_W-1:0]        domain_depth,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_last,
  output logic [pgb_pkg::OUT_TDATA_W-1:0]  out_data
);
  import pgb_pkg::*;

  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int IW    = (RW > CW) ? RW : CW;
  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(SLOTS_PER_CELL + 1);
  localparam int MW    = EPOCH_W + KW;
  localparam int PCW   = $clog2(MAX_PARTICLES + 1);
  localparam int CAP   = DEPTH * SLOTS_PER_CELL;
  localparam int TW    = $clog2(CAP + 1);
  localparam int SW    = (PCW > TW) ? PCW : TW;
  localparam int DCW   = $clog2(IW + 1);

  localparam logic [IW-1:0]  ROW_LAST   = IW'(GRID_ROWS - 1);
  localparam logic [IW-1:0]  COL_LAST   = IW'(GRID_COLS - 1);
  localparam logic [DCW-1:0] DIV_LAST   = DCW'(IW - 1);
  localparam logic [AW-1:0]  DEPTH_LAST = AW'(DEPTH - 1);
  localparam logic [KW-1:0]  SLOTS_K    = KW'(SLOTS_PER_CELL);
  localparam logic [PCW-1:0] MAX_P      = PCW'(MAX_PARTICLES);

  logic                 last_r;
  logic [POS_W-1:0]     pos_x, pos_y;
  logic [EPOCH_W-1:0]   epoch;
  logic [AW-1:0]        clr_addr;
  logic [REG_W-1:0]     rem;
  logic [IW-1:0]        ulo, quo;
  logic [DCW-1:0]       dcnt;
  logic                 force_zero, force_last;
  logic [RW-1:0]        row;
  logic [CW-1:0]        col;
  logic [PCW-1:0]       pcount;
  logic [TW-1:0]        placed;

  logic [POS_W-1:0]     u_sel;
  logic [REG_W-1:0]     u_mag, ext_sel, rem_init;
  logic                 sat0;
  logic [REG_W:0]       shifted;
  logic                 fits;
  logic [REG_W-1:0]     rem_step;
  logic [IW:0]          quo_ext, ulo_ext;
  logic [IW-1:0]        quo_step, last_sel, idx_final;

  logic [AW-1:0]        cell_addr, ram_addr;
  logic                 ram_we;
  logic [MW-1:0]        ram_wdata, ram_rdata;
  logic [EPOCH_W-1:0]   tag;
  logic [KW-1:0]        cnt_eff;
  logic                 stored;

  logic [PCW-1:0]       pcount_next;
  logic [TW-1:0]        placed_next;
  logic                 all_binned;
  logic [PCW+IDX_W-1:0] idx_wide;
  logic [RW+ROW_W-1:0]  row_wide;
  logic [CW+COL_W-1:0]  col_wide;
  logic [KW+SLOT_W-1:0] slot_wide;
  logic [TW+TOTAL_W-1:0] total_wide;

  // divider: high part checked once for saturation, then one quotient bit a step
  assign u_sel     = cmd.axis_y ? pos_y : pos_x;
  assign ext_sel   = cmd.axis_y ? domain_depth : domain_length;
  assign u_mag     = u_sel[REG_W-1:0];
  assign rem_init  = u_mag >> IW;
  assign sat0      = rem_init >= cell_size;
  assign shifted   = {rem, ulo[IW-1]};
  assign fits      = shifted >= {1'b0, cell_size};
  assign rem_step  = fits ? REG_W'(shifted - {1'b0, cell_size}) : shifted[REG_W-1:0];
  assign quo_ext   = {quo, fits};
  assign quo_step  = quo_ext[IW-1:0];
  assign ulo_ext   = {ulo, 1'b0};
  assign last_sel  = cmd.axis_y ? ROW_LAST : COL_LAST;
  assign idx_final = force_zero ? '0 :
                     (force_last || quo_step > last_sel) ? last_sel : quo_step;

  assign cell_addr = AW'(row * GRID_COLS + col);
  assign ram_addr  = cmd.clr_step ? clr_addr : cell_addr;
  assign tag       = ram_rdata[MW-1:KW];
  assign cnt_eff   = (tag == epoch) ? ram_rdata[KW-1:0] : '0;
  assign stored    = cnt_eff < SLOTS_K;
  assign ram_we    = cmd.clr_step || (cmd.wr && stored);
  assign ram_wdata = cmd.clr_step ? {epoch, {KW{1'b0}}} : {epoch, KW'(cnt_eff + 1'b1)};

  pgb_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pcount_next = (pcount < MAX_P) ? PCW'(pcount + 1'b1) : pcount;
  assign placed_next = TW'(placed + TW'(stored));
  assign all_binned  = last_r && (SW'(placed_next) == SW'(pcount_next));
  assign idx_wide    = {{IDX_W{1'b0}}, pcount};
  assign row_wide    = {{ROW_W{1'b0}}, row};
  assign col_wide    = {{COL_W{1'b0}}, col};
  assign slot_wide   = {{SLOT_W{1'b0}}, (stored ? cnt_eff : {KW{1'b0}})};
  assign total_wide  = {{TOTAL_W{1'b0}}, placed_next};

  assign sts.first    = in_first;
  assign sts.wrap     = &epoch;
  assign sts.clr_done = clr_addr == DEPTH_LAST;
  assign sts.div_done = dcnt == DIV_LAST;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= '0;
      clr_addr  <= '0;
      pcount    <= '0;
      placed    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept && in_first) begin
        epoch  <= EPOCH_W'(epoch + 1'b1);
        pcount <= '0;
        placed <= '0;
      end
      if (cmd.clr_step) begin
        clr_addr <= sts.clr_done ? '0 : AW'(clr_addr + 1'b1);
      end
      if (cmd.wr) begin
        pcount    <= pcount_next;
        placed    <= placed_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_r <= in_last;
      pos_x  <= in_pos_x;
      pos_y  <= in_pos_y;
    end
    if (cmd.div_init) begin
      rem        <= rem_init;
      ulo        <= u_mag[IW-1:0];
      quo        <= '0;
      dcnt       <= '0;
      force_zero <= u_sel[POS_W-1];
      force_last <= (u_mag >= ext_sel) || sat0;
    end
    if (cmd.div_step) begin
      rem  <= rem_step;
      ulo  <= ulo_ext[IW-1:0];
      quo  <= quo_step;
      dcnt <= DCW'(dcnt + 1'b1);
      if (sts.div_done) begin
        if (cmd.axis_y) begin
          row <= idx_final[RW-1:0];
        end else begin
          col <= idx_final[CW-1:0];
        end
      end
    end
    if (cmd.wr) begin
      out_last <= last_r;
      out_data <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                   total_wide[TOTAL_W-1:0],
                   all_binned,
                   stored,
                   slot_wide[SLOT_W-1:0],
                   col_wide[COL_W-1:0],
                   row_wide[ROW_W-1:0],
                   idx_wide[IDX_W-1:0]};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/particle_grid_binning_unit.sv =====
// Top level: stream ports, configuration registers, controller and datapath.
// Each beat is divided for its column (x) and then its row (y), IW quotient bits per
//   axis, IW the wider of the row and column index widths; the cell count follows.
// A new beat waits for the previous result to be registered; both axes share the divider.
// Reset: a clearing pass over all GRID_ROWS*GRID_COLS (4096) cells holds tready low;
//   the same pass runs on a first beat once every 2**EPOCH_W frames.
`default_nettype none
module particle_grid_binning_unit #(
  parameter int GRID_ROWS      = pgb_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS      = pgb_pkg::GRID_COLS_DEF,
  parameter int SLOTS_PER_CELL = pgb_pkg::SLOTS_DEF,
  parameter int MAX_PARTICLES  = pgb_pkg::MAX_PARTICLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y
  input  logic                             s_axis_tuser,  // first_item
  input  logic                             s_axis_tlast,  // last_item
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // particle_index, cell_row, cell_col, slot, stored, all_binned, stored_total
  output logic [pgb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,  // frame_done
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pgb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pgb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pgb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pgb_pkg::*;

  logic [REG_W-1:0] cell_size, domain_length, domain_depth;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  cmd_t             cmd;
  status_t          sts;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size     <= CELL_SIZE_RST;
      domain_length <= DOMAIN_RST;
      domain_depth  <= DOMAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CELL_SIZE:     cell_size     <= pwdata[REG_W-1:0];
        REG_DOMAIN_LENGTH: domain_length <= pwdata[REG_W-1:0];
        REG_DOMAIN_DEPTH:  domain_depth  <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CELL_SIZE:     prdata = {1'b0, cell_size};
      REG_DOMAIN_LENGTH: prdata = {1'b0, domain_length};
      REG_DOMAIN_DEPTH:  prdata = {1'b0, domain_depth};
      default:           prdata = '0;
    endcase
  end

  pgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgb_datapath #(
    .GRID_ROWS      (GRID_ROWS),
    .GRID_COLS      (GRID_COLS),
    .SLOTS_PER_CELL (SLOTS_PER_CELL),
    .MAX_PARTICLES  (MAX_PARTICLES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_first      (s_axis_tuser),
    .in_last       (s_axis_tlast),
    .in_pos_x      (s_axis_tdata[POS_W-1:0]),
    .in_pos_y      (s_axis_tdata[2*POS_W-1:POS_W]),
    .cell_size     (cell_size),
    .domain_length (domain_length),
    .domain_depth  (domain_depth),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_last      (m_axis_tlast),
    .out_data      (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input beat accepted while an item is in flight");

  a_dropped_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[OUT_STORED_BIT] |->
      m_axis_tdata[OUT_SLOT_LSB +: SLOT_W] == '0)
    else $error("dropped particle reports a nonzero slot");

  a_summary_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[OUT_ALL_BIT])
    else $error("all_binned set on a beat that does not end the frame");
`endif

endmodule
`default_nettype wire

// ===== dv/pgb_checker.sv =====
// Watches the particle binning unit's channels, predicts each result and compares it.
`timescale 1ns / 1ps
module pgb_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [pgb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pos_x, pos_y
  input  logic                               s_axis_tuser,  // first_item
  input  logic                               s_axis_tlast,  // last_item
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // particle_index, cell_row, cell_col, slot, stored, all_binned, stored_total
  input  logic [pgb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               m_axis_tlast,  // frame_done
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [pgb_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pgb_pkg::CFG_DATA_W-1:0]     pwdata,
  output int                                 fails,
  output int                                 outstanding
);
  import pgb_pkg::*;

  localparam int unsigned CELLS = GRID_ROWS_DEF * GRID_COLS_DEF;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SLOT_W-1:0]  slot;
    logic               stored;
    logic               done;
    logic               all_binned;
    logic [TOTAL_W-1:0] total;
  } bin_result_t;

  logic [REG_W-1:0]  cell_size_q;
  logic [REG_W-1:0]  length_q;
  logic [REG_W-1:0]  depth_q;
  logic [SLOT_W-1:0] fill [CELLS];
  int unsigned       frame_count;
  int unsigned       frame_placed;
  bin_result_t       expected_bins[$];

  initial begin
    fails = 0;
    outstanding = 0;
  end

  function automatic int unsigned coord_to_cell(logic [31:0] pos, logic [REG_W-1:0] extent,
                                                int unsigned cells);
    logic [31:0] q;
    if (pos[31]) return 0;
    if (pos >= {1'b0, extent}) return cells - 1;
    q = (cell_size_q == '0) ? '1 : pos / {1'b0, cell_size_q};
    return (q > cells - 1) ? cells - 1 : q;
  endfunction

  function automatic bin_result_t bin_particle(logic first, logic last, logic [31:0] x,
                                               logic [31:0] y);
    bin_result_t r;
    int unsigned row;
    int unsigned col;
    int unsigned cell_id;
    if (first) begin
      foreach (fill[i]) fill[i] = '0;
      frame_count = 0;
      frame_placed = 0;
    end
    row = coord_to_cell(y, depth_q, GRID_ROWS_DEF);
    col = coord_to_cell(x, length_q, GRID_COLS_DEF);
    cell_id = row * GRID_COLS_DEF + col;
    r = '0;
    if (fill[cell_id] < SLOTS_DEF) begin
      r.slot = fill[cell_id];
      fill[cell_id] = fill[cell_id] + 1'b1;
      r.stored = 1'b1;
      frame_placed++;
    end
    r.index = IDX_W'(frame_count);
    if (frame_count < MAX_PARTICLES_DEF) frame_count++;
    r.row = ROW_W'(row);
    r.col = COL_W'(col);
    r.done = last;
    r.all_binned = last && (frame_placed == frame_count);
    r.total = TOTAL_W'(frame_placed);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    bin_result_t want;
    bin_result_t got;
    if (rst) begin
      cell_size_q = CELL_SIZE_RST;
      length_q = DOMAIN_RST;
      depth_q = DOMAIN_RST;
      foreach (fill[i]) fill[i] = '0;
      frame_count = 0;
      frame_placed = 0;
      expected_bins.delete();
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CELL_SIZE:     cell_size_q = pwdata[REG_W-1:0];
          REG_DOMAIN_LENGTH: length_q = pwdata[REG_W-1:0];
          REG_DOMAIN_DEPTH:  depth_q = pwdata[REG_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[IDX_W-1:0];
        got.row = m_axis_tdata[OUT_ROW_LSB +: ROW_W];
        got.col = m_axis_tdata[OUT_COL_LSB +: COL_W];
        got.slot = m_axis_tdata[OUT_SLOT_LSB +: SLOT_W];
        got.stored = m_axis_tdata[OUT_STORED_BIT];
        got.done = m_axis_tlast;
        got.all_binned = m_axis_tdata[OUT_ALL_BIT];
        got.total = m_axis_tdata[OUT_TOTAL_LSB +: TOTAL_W];
        if (expected_bins.size() == 0) begin
          $error("result beat with no particle pending");
          fails++;
        end else begin
          want = expected_bins.pop_front();
          check_field("particle_index", want.index, got.index);
          check_field("cell_row", want.row, got.row);
          check_field("cell_col", want.col, got.col);
          check_field("slot", want.slot, got.slot);
          check_field("stored", want.stored, got.stored);
          check_field("frame_done", want.done, got.done);
          check_field("all_binned", want.all_binned, got.all_binned);
          check_field("stored_total", want.total, got.total);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_bins.push_back(bin_particle(s_axis_tuser, s_axis_tlast,
                                             s_axis_tdata[31:0], s_axis_tdata[63:32]));
      outstanding = expected_bins.size();
    end
  end

endmodule

// ===== dv/tb_particle_grid_binning_unit.sv =====
// Top of the particle binning testbench: clock, reset, stimulus, config writes and verdict.
`timescale 1ns / 1ps
module tb_particle_grid_binning_unit;
  import pgb_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;   // pos_x, pos_y
  logic                    s_axis_tuser;   // first_item
  logic                    s_axis_tlast;   // last_item
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // particle_index, cell_row, cell_col, slot, stored, all_binned, stored_total
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;   // frame_done
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  int fails;
  int outstanding;

  bit               tx_steady;
  bit               rx_steady;
  logic [REG_W-1:0] cell_now;
  logic [REG_W-1:0] len_now;
  logic [REG_W-1:0] dep_now;

  particle_grid_binning_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pgb_checker u_bin_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fails         (fails),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("tb_particle_grid_binning_unit failed");
    $finish;
  end

  function automatic int unsigned idle_cycles(bit steady);
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [REG_W-1:0] scaled_extent(logic [REG_W-1:0] step);
    longint v;
    v = longint'(step) * $urandom_range(0, 70);
    return (v > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : v[REG_W-1:0];
  endfunction

  // Bias toward a few cells near the origin so buckets fill up.
  function automatic logic [31:0] pick_coord(logic [REG_W-1:0] step, logic [REG_W-1:0] extent,
                                             int unsigned span);
    int unsigned sel;
    int unsigned c;
    longint      v;
    sel = $urandom_range(0, 9);
    c = $urandom_range(0, span);
    if (sel == 6) return $urandom;
    if (sel == 7) return {1'b1, 31'($urandom)};
    if (sel == 8) begin
      v = longint'(extent) + $urandom_range(0, 2) - 1;
      return 32'(v);
    end
    if (sel == 9) begin
      v = longint'($urandom_range(1, 64)) * step - $urandom_range(0, 1);
    end else begin
      if (step == '0) return {1'b0, 31'($urandom_range(0, extent))};
      v = longint'(c) * step + ($urandom % step);
    end
    if (v > 64'sh7FFF_FFFF || v < 0) return {1'b0, 31'($urandom)};
    return 32'(v);
  endfunction

  task automatic write_reg(reg_idx_t r, logic [REG_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = {1'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_particle(logic first, logic last, logic [31:0] x, logic [31:0] y);
    int unsigned gap;
    gap = idle_cycles(tx_steady);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = first;
    s_axis_tlast = last;
    s_axis_tdata = {y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_frames(int unsigned budget);
    int unsigned len;
    int unsigned span;
    bit          open;
    bit          close;
    bit          first;
    bit          last;
    while (budget > 0) begin
      if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 2);
      if (len > budget) len = budget;
      span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      open = $urandom_range(0, 9) != 0;
      close = $urandom_range(0, 9) != 0;
      for (int unsigned k = 0; k < len; k++) begin
        first = (k == 0 && open) || ($urandom_range(0, 31) == 0);
        last = (k == len - 1 && close) || ($urandom_range(0, 31) == 0);
        send_particle(first, last, pick_coord(cell_now, len_now, span),
                      pick_coord(cell_now, dep_now, span));
      end
      budget -= len;
    end
  endtask

  // Drain results, stalling for a random time before each beat while rx_steady is clear.
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_cycles(rx_steady);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    cell_now = CELL_SIZE_RST;
    len_now = DOMAIN_RST;
    dep_now = DOMAIN_RST;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Field extremes and domain edges on the reset grid.
    send_particle(1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000);
    send_particle(1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_particle(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_particle(1'b0, 1'b0, 32'hFFFF_FFFF, 32'h003F_FFFF);
    send_particle(1'b0, 1'b0, 32'h0040_0000, 32'h0001_0000);
    // Overfill one bucket so the last particle is dropped.
    for (int k = 0; k < 16; k++)
      send_particle(1'b0, k == 15, 32'h0001_8000, 32'h0001_8000);
    send_particle(1'b1, 1'b0, 32'h0002_0000, 32'h0003_0000);
    send_particle(1'b0, 1'b1, 32'h0002_0000, 32'h0003_0000);
    // Continue the frame without a first beat.
    send_particle(1'b0, 1'b1, 32'h0001_0000, 32'h0002_0000);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin cell_now = CELL_SIZE_RST; len_now = DOMAIN_RST; dep_now = DOMAIN_RST; end
        1: begin cell_now = 31'd1; len_now = 31'h7FFF_FFFF; dep_now = 31'h7FFF_FFFF; end
        2: begin cell_now = 31'h7FFF_FFFF; len_now = 31'h7FFF_FFFF; dep_now = 31'h7FFF_FFFF; end
        3: begin cell_now = 31'd0; len_now = 31'h0010_0000; dep_now = 31'h7FFF_FFFF; end
        4: begin cell_now = CELL_SIZE_RST; len_now = 31'd0; dep_now = 31'd0; end
        default: begin
          cell_now = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(1, 32'h0004_0000));
          len_now = scaled_extent(cell_now);
          dep_now = scaled_extent(cell_now);
        end
      endcase
      wait_drained();
      write_reg(REG_CELL_SIZE, cell_now);
      write_reg(REG_DOMAIN_LENGTH, len_now);
      write_reg(REG_DOMAIN_DEPTH, dep_now);
      run_frames(90);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fails == 0) begin
      $display("tb_particle_grid_binning_unit passed");
    end else begin
      $display("tb_particle_grid_binning_unit failed");
    end
    $finish;
  end

endmodule
